// ===== hdl/cse_pkg.sv =====
package cse_pkg;

   // parser phase
   typedef enum logic [2:0] {
      PH_TEXT = 3'd0,
      PH_ESC  = 3'd1,
      PH_HEX0 = 3'd2,
      PH_HEX1 = 3'd3,
      PH_OCT  = 3'd4,
      PH_NUM  = 3'd5
   } phase_type;

   // token kinds
   localparam logic [2:0] KIND_CHAR  = 3'd0;
   localparam logic [2:0] KIND_END   = 3'd1;
   localparam logic [2:0] KIND_DELAY = 3'd2;
   localparam logic [2:0] KIND_SEND  = 3'd3;
   localparam logic [2:0] KIND_WAIT  = 3'd4;

   localparam int VALUE_BITS_DEFAULT = 32;
   localparam int TOKEN_BITS         = 32;

   typedef struct packed {
      logic [2:0]            kind;
      logic [TOKEN_BITS-1:0] value;
      logic                  last;
   } token_type;

endpackage

// ===== hdl/cse_decode.sv =====
module cse_decode import cse_pkg::*; #(
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
   input  phase_type             phase,
   input  logic [VALUE_BITS-1:0] acc,
   input  logic [1:0]            oct_cnt,
   input  logic                  pend_wait,
   input  logic [7:0]            char_code,
   output logic [1:0]            tok_count,
   output token_type             tok0,
   output token_type             tok1,
   output phase_type             phase_in,
   output logic [VALUE_BITS-1:0] acc_in,
   output logic [1:0]            oct_cnt_in,
   output logic                  pend_wait_in
);

   logic [7:0] c;
   assign c = char_code;

   // plain text handling of one byte
   function automatic logic plain_emits(input logic [7:0] b);
      plain_emits = (b != 8'h5c);
   endfunction

   function automatic token_type plain_tok(input logic [7:0] b);
      token_type t;
      t = '0;
      if (b == 8'h00) begin
         t.kind = KIND_END;
      end else begin
         t.kind  = KIND_CHAR;
         t.value = {{(TOKEN_BITS-8){1'b0}}, b};
      end
      plain_tok = t;
   endfunction

   function automatic phase_type plain_phase(input logic [7:0] b);
      plain_phase = (b == 8'h5c) ? PH_ESC : PH_TEXT;
   endfunction

   function automatic logic hex_ok(input logic [7:0] b);
      hex_ok = (b inside {["0":"9"], ["a":"f"], ["A":"F"]});
   endfunction

   function automatic logic [3:0] hex_val(input logic [7:0] b);
      logic [7:0] d;
      d = 8'h00;
      if (b inside {["0":"9"]}) d = b - 8'h30;
      else if (b inside {["a":"f"]}) d = b - 8'h57;
      else if (b inside {["A":"F"]}) d = b - 8'h37;
      hex_val = d[3:0];
   endfunction

   function automatic token_type char_tok(input logic [8:0] v);
      token_type t;
      t       = '0;
      t.kind  = KIND_CHAR;
      t.value = {{(TOKEN_BITS-9){1'b0}}, v};
      char_tok = t;
   endfunction

   // decimal accumulate with saturation
   logic                  is_dec;
   logic                  is_oct;
   logic [VALUE_BITS+3:0] dec_sum;
   logic [VALUE_BITS-1:0] dec_next;
   assign is_dec   = (c inside {["0":"9"]});
   assign is_oct   = (c inside {["0":"7"]});
   assign dec_sum  = ({4'b0, acc} << 3) + ({4'b0, acc} << 1)
                   + {{VALUE_BITS{1'b0}}, c[3:0]};
   assign dec_next = (dec_sum[VALUE_BITS+3:VALUE_BITS] != 4'd0) ? '1
                                                                : dec_sum[VALUE_BITS-1:0];

   // count finish: a zero count becomes one, seconds scale by 1000 with saturation
   logic [VALUE_BITS-1:0]  cnt_v;
   logic [VALUE_BITS+9:0]  prod;
   logic [VALUE_BITS-1:0]  secs_v;
   logic [VALUE_BITS-1:0]  ms_v;
   logic [VALUE_BITS+31:0] ms_ext;
   assign cnt_v  = (acc == '0) ? {{(VALUE_BITS-1){1'b0}}, 1'b1} : acc;
   assign prod   = ({10'b0, cnt_v} << 10) - ({10'b0, cnt_v} << 4) - ({10'b0, cnt_v} << 3);
   assign secs_v = (prod[VALUE_BITS+9:VALUE_BITS] != 10'd0) ? '1 : prod[VALUE_BITS-1:0];
   assign ms_v   = (c == "m") ? cnt_v : secs_v;
   assign ms_ext = {{TOKEN_BITS{1'b0}}, ms_v};

   // octal accumulate
   logic [8:0] oct_acc;
   logic [1:0] oct_cnt_nx;
   logic       oct_done;
   assign oct_acc    = {acc[5:0], c[2:0]};
   assign oct_cnt_nx = oct_cnt + 2'd1;
   assign oct_done   = (oct_cnt_nx == 2'd3) || (oct_cnt_nx == 2'd0);

   // token outputs
   always_comb begin
      token_type t0;
      token_type t1;
      logic [1:0] n;
      t0 = '0;
      t1 = '0;
      n  = 2'd0;
      case (phase)
         PH_ESC: begin
            n = 2'd1;
            t0.kind = KIND_CHAR;
            case (c)
               8'h00:   t0.kind = KIND_END;
               "a":     t0.value = 32'd7;
               "b":     t0.value = 32'd8;
               "f":     t0.value = 32'd12;
               "n":     t0.value = 32'd10;
               "r":     t0.value = 32'd13;
               "t":     t0.value = 32'd9;
               "v":     t0.value = 32'd11;
               "s":     t0.kind = KIND_SEND;
               "x", "d", "w": n = 2'd0;
               default: begin
                  if (is_oct) n = 2'd0;
                  else t0.value = {{(TOKEN_BITS-8){1'b0}}, c};
               end
            endcase
         end
         PH_HEX0: begin
            if (!hex_ok(c)) begin
               n  = 2'd1;
               t0 = plain_tok(c);
            end
         end
         PH_HEX1: begin
            n = 2'd1;
            if (hex_ok(c)) begin
               t0 = char_tok({1'b0, acc[3:0], hex_val(c)});
            end else begin
               t0 = char_tok({5'd0, acc[3:0]});
               t1 = plain_tok(c);
               if (plain_emits(c)) n = 2'd2;
            end
         end
         PH_OCT: begin
            if (is_oct) begin
               if (oct_done) begin
                  n  = 2'd1;
                  t0 = char_tok(oct_acc);
               end
            end else begin
               n  = 2'd1;
               t0 = char_tok(acc[8:0]);
               t1 = plain_tok(c);
               if (plain_emits(c)) n = 2'd2;
            end
         end
         PH_NUM: begin
            if (!is_dec) begin
               n        = 2'd1;
               t0.kind  = pend_wait ? KIND_WAIT : KIND_DELAY;
               t0.value = ms_ext[TOKEN_BITS-1:0];
               t1       = plain_tok(c);
               if (c != "m" && c != "s" && plain_emits(c)) n = 2'd2;
            end
         end
         default: begin
            t0 = plain_tok(c);
            if (plain_emits(c)) n = 2'd1;
         end
      endcase
      // mark the final token of this transaction
      if (n == 2'd1) t0.last = 1'b1;
      if (n == 2'd2) t1.last = 1'b1;
      tok0      = t0;
      tok1      = t1;
      tok_count = n;
   end

   // next parser state
   always_comb begin
      phase_in     = PH_TEXT;
      acc_in       = acc;
      oct_cnt_in   = oct_cnt;
      pend_wait_in = pend_wait;
      case (phase)
         PH_ESC: begin
            case (c)
               "x": phase_in = PH_HEX0;
               "d", "w": begin
                  phase_in     = PH_NUM;
                  acc_in       = '0;
                  pend_wait_in = (c == "w");
               end
               default: begin
                  if (is_oct) begin
                     phase_in   = PH_OCT;
                     acc_in     = {{(VALUE_BITS-3){1'b0}}, c[2:0]};
                     oct_cnt_in = 2'd1;
                  end
               end
            endcase
         end
         PH_HEX0: begin
            if (hex_ok(c)) begin
               phase_in = PH_HEX1;
               acc_in   = {{(VALUE_BITS-4){1'b0}}, hex_val(c)};
            end
         end
         PH_HEX1: begin
            acc_in = '0;
            if (!hex_ok(c)) phase_in = plain_phase(c);
         end
         PH_OCT: begin
            if (is_oct) begin
               if (oct_done) begin
                  acc_in     = '0;
                  oct_cnt_in = 2'd0;
               end else begin
                  phase_in   = PH_OCT;
                  acc_in     = {{(VALUE_BITS-9){1'b0}}, oct_acc};
                  oct_cnt_in = oct_cnt_nx;
               end
            end else begin
               acc_in     = '0;
               oct_cnt_in = 2'd0;
               phase_in   = plain_phase(c);
            end
         end
         PH_NUM: begin
            if (is_dec) begin
               phase_in = PH_NUM;
               acc_in   = dec_next;
            end else begin
               acc_in       = '0;
               pend_wait_in = 1'b0;
               if (c != "m" && c != "s") phase_in = plain_phase(c);
            end
         end
         default: phase_in = plain_phase(c);
      endcase
   end

endmodule

// ===== hdl/chat_script_escape_decoder_unit.sv =====
// A token is registered and appears on rsp in the cycle after its character is accepted.
// Throughput: one character per cycle when each yields at most one token and rsp is not
// stalled; a character that yields two tokens stalls req while the two-token output
// buffer drains, so the rate is set by one token per cycle on the rsp side.
// Reset (synchronous, active high) returns the parser to plain text and empties the buffer.
module chat_script_escape_decoder_unit import cse_pkg::*; #(
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_char_code,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [2:0]            rsp_token_kind,
   output logic [TOKEN_BITS-1:0] rsp_token_value,
   output logic                  rsp_last_of_run
);

   phase_type             phase_ff, phase_in;
   logic [VALUE_BITS-1:0] acc_ff, acc_in;
   logic [1:0]            oct_cnt_ff, oct_cnt_in;
   logic                  wait_ff, wait_in;

   token_type             slot0_ff, slot0_in;
   token_type             slot1_ff, slot1_in;
   logic [1:0]            cnt_ff, cnt_in;

   logic [1:0]            tok_count;
   token_type             tok0, tok1;
   logic                  accept;
   logic                  take;

   cse_decode #(
      .VALUE_BITS (VALUE_BITS)
   ) u_decode (
      .phase        (phase_ff),
      .acc          (acc_ff),
      .oct_cnt      (oct_cnt_ff),
      .pend_wait    (wait_ff),
      .char_code    (req_char_code),
      .tok_count    (tok_count),
      .tok0         (tok0),
      .tok1         (tok1),
      .phase_in     (phase_in),
      .acc_in       (acc_in),
      .oct_cnt_in   (oct_cnt_in),
      .pend_wait_in (wait_in)
   );

   // handshake: accept once the buffer is empty or drains this cycle
   assign rsp_valid = (cnt_ff != 2'd0);
   assign take      = rsp_valid && !rsp_stall;
   assign req_stall = !((cnt_ff == 2'd0) || (cnt_ff == 2'd1 && !rsp_stall));
   assign accept    = req_valid && !req_stall;

   assign rsp_token_kind  = slot0_ff.kind;
   assign rsp_token_value = slot0_ff.value;
   assign rsp_last_of_run = slot0_ff.last;

   // load the buffer on a new transaction, else advance on a take
   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      cnt_in   = cnt_ff;
      if (accept) begin
         slot0_in = tok0;
         slot1_in = tok1;
         cnt_in   = tok_count;
      end else if (take) begin
         slot0_in = slot1_ff;
         cnt_in   = cnt_ff - 2'd1;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_TEXT;
         acc_ff     <= '0;
         oct_cnt_ff <= 2'd0;
         wait_ff    <= 1'b0;
         cnt_ff     <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
         if (accept) begin
            phase_ff   <= phase_in;
            acc_ff     <= acc_in;
            oct_cnt_ff <= oct_cnt_in;
            wait_ff    <= wait_in;
         end
      end
   end

   // token payload
   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

`ifndef SYNTHESIS
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3) else $error("token buffer count out of range");

   a_full_stalls: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2) |-> req_stall) else $error("accepted with full buffer");

   a_single_last: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd1) |-> rsp_last_of_run) else $error("lone token not last");

   a_pair_first: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2) |-> !rsp_last_of_run) else $error("first of pair marked last");
`endif

endmodule

// ===== tb/chat_script_escape_decoder_unit_test.sv =====
module chat_script_escape_decoder_unit_test;
   import cse_pkg::*;

   localparam int VALUE_BITS = VALUE_BITS_DEFAULT;
   localparam logic [63:0] COUNT_MAX =
      (VALUE_BITS >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF : ((64'd1 << VALUE_BITS) - 64'd1);
   localparam int RANDOM_CHARS = 850;
   localparam int HOLD_CYCLES  = 150;
   localparam int SETTLE_CYCLES = 8;

   typedef struct packed {
      logic [7:0]  code;
      logic        typed;
      logic [2:0]  kind;
      logic [31:0] value;
   } stim_row_type;

   // directed script; typed rows carry their expected token in the table
   localparam stim_row_type DIRECTED_ROWS [0:24] = '{
      '{8'h00, 1'b1, KIND_END,   32'd0},
      '{8'hFF, 1'b1, KIND_CHAR,  32'd255},
      '{"\\",  1'b0, KIND_CHAR,  32'd0},
      '{"s",   1'b1, KIND_SEND,  32'd0},
      '{"\\",  1'b0, KIND_CHAR,  32'd0},
      '{"x",   1'b0, KIND_CHAR,  32'd0},
      '{"F",   1'b0, KIND_CHAR,  32'd0},
      '{"f",   1'b1, KIND_CHAR,  32'd255},
      '{"\\",  1'b0, KIND_CHAR,  32'd0},
      '{"7",   1'b0, KIND_CHAR,  32'd0},
      '{"7",   1'b0, KIND_CHAR,  32'd0},
      '{"7",   1'b1, KIND_CHAR,  32'd511},
      '{"\\",  1'b0, KIND_CHAR,  32'd0},
      '{"w",   1'b0, KIND_CHAR,  32'd0},
      '{"m",   1'b1, KIND_WAIT,  32'd1},
      '{"\\",  1'b0, KIND_CHAR,  32'd0},
      '{"d",   1'b0, KIND_CHAR,  32'd0},
      '{"4",   1'b0, KIND_CHAR,  32'd0},
      '{"\\",  1'b0, KIND_CHAR,  32'd0},
      '{"x",   1'b0, KIND_CHAR,  32'd0},
      '{"g",   1'b0, KIND_CHAR,  32'd0},
      '{"\\",  1'b0, KIND_CHAR,  32'd0},
      '{8'h00, 1'b1, KIND_END,   32'd0},
      '{"\\",  1'b0, KIND_CHAR,  32'd0},
      '{"9",   1'b1, KIND_CHAR,  32'd57}
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [7:0]            req_char_code = 8'h00;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [2:0]            rsp_token_kind;
   logic [TOKEN_BITS-1:0] rsp_token_value;
   logic                  rsp_last_of_run;

   // decoder shadow state
   phase_type   parse_phase = PH_TEXT;
   logic [63:0] count_acc = '0;
   logic [1:0]  oct_digits = '0;
   logic        wait_pending = 1'b0;

   token_type   step_tokens[$];
   token_type   pending_tokens[$];
   logic [7:0]  script_bytes[$];

   int error_count = 0;
   int chars_sent = 0;
   int tokens_checked = 0;
   int timed_tokens = 0;
   int burst_left = 10;
   int cycle_count = 0;
   int hold_left = 0;
   int stall_mode = 0;

   chat_script_escape_decoder_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_char_code   (req_char_code),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_token_kind  (rsp_token_kind),
      .rsp_token_value (rsp_token_value),
      .rsp_last_of_run (rsp_last_of_run)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("chat_script_escape_decoder_unit_test: FAIL");
      $finish;
   end

   function automatic int hex_digit(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c - "0");
      if (c >= "a" && c <= "f") return int'(c - "a") + 10;
      if (c >= "A" && c <= "F") return int'(c - "A") + 10;
      return -1;
   endfunction

   function automatic void emit_token(logic [2:0] kind, logic [63:0] value);
      token_type t;
      t.kind = kind;
      t.value = value[TOKEN_BITS-1:0];
      t.last = 1'b0;
      step_tokens.push_back(t);
   endfunction

   // plain text: literal, end of string, or start of an escape
   function automatic void text_char(logic [7:0] c);
      parse_phase = PH_TEXT;
      if (c == 8'h00) emit_token(KIND_END, 64'd0);
      else if (c == "\\") parse_phase = PH_ESC;
      else emit_token(KIND_CHAR, {56'd0, c});
   endfunction

   function automatic void escape_char(logic [7:0] c);
      parse_phase = PH_TEXT;
      case (c)
         8'h00: emit_token(KIND_END, 64'd0);
         "a": emit_token(KIND_CHAR, 64'd7);
         "b": emit_token(KIND_CHAR, 64'd8);
         "f": emit_token(KIND_CHAR, 64'd12);
         "n": emit_token(KIND_CHAR, 64'd10);
         "r": emit_token(KIND_CHAR, 64'd13);
         "t": emit_token(KIND_CHAR, 64'd9);
         "v": emit_token(KIND_CHAR, 64'd11);
         "s": emit_token(KIND_SEND, 64'd0);
         "x": parse_phase = PH_HEX0;
         "d", "w": begin
            wait_pending = (c == "w");
            count_acc = '0;
            parse_phase = PH_NUM;
         end
         default: begin
            if (c >= "0" && c <= "7") begin
               count_acc = {56'd0, c - 8'd48};
               oct_digits = 2'd1;
               parse_phase = PH_OCT;
            end else begin
               emit_token(KIND_CHAR, {56'd0, c});
            end
         end
      endcase
   endfunction

   // advance the shadow decoder by one character; tokens land in step_tokens
   function automatic void decode_char(logic [7:0] c);
      int h;
      logic [63:0] digit;
      logic [63:0] acc;
      logic [63:0] ms;
      bit unit_used;
      token_type t;
      step_tokens.delete();
      case (parse_phase)
         PH_ESC: escape_char(c);
         PH_HEX0: begin
            parse_phase = PH_TEXT;
            h = hex_digit(c);
            if (h >= 0) begin
               count_acc = 64'(h);
               parse_phase = PH_HEX1;
            end else if (c == 8'h00) begin
               emit_token(KIND_END, 64'd0);
            end else begin
               emit_token(KIND_CHAR, {56'd0, c});
            end
         end
         PH_HEX1: begin
            parse_phase = PH_TEXT;
            h = hex_digit(c);
            if (h >= 0) begin
               emit_token(KIND_CHAR, {60'd0, count_acc[3:0]} * 64'd16 + 64'(h));
            end else begin
               emit_token(KIND_CHAR, {60'd0, count_acc[3:0]});
               text_char(c);
            end
            count_acc = '0;
         end
         PH_OCT: begin
            if (c >= "0" && c <= "7") begin
               count_acc = ((count_acc * 64'd8) + {56'd0, c - 8'd48}) & 64'h1FF;
               oct_digits = oct_digits + 2'd1;
               if (oct_digits >= 2'd3 || oct_digits == 2'd0) begin
                  emit_token(KIND_CHAR, count_acc);
                  count_acc = '0;
                  oct_digits = '0;
                  parse_phase = PH_TEXT;
               end
            end else begin
               emit_token(KIND_CHAR, count_acc & 64'h1FF);
               count_acc = '0;
               oct_digits = '0;
               text_char(c);
            end
         end
         PH_NUM: begin
            if (c >= "0" && c <= "9") begin
               digit = {56'd0, c - 8'd48};
               acc = count_acc & COUNT_MAX;
               if (acc > (COUNT_MAX - digit) / 64'd10) count_acc = COUNT_MAX;
               else count_acc = acc * 64'd10 + digit;
            end else begin
               ms = count_acc & COUNT_MAX;
               unit_used = 1'b0;
               if (ms == 64'd0) ms = 64'd1;
               if (c == "m") begin
                  unit_used = 1'b1;
               end else begin
                  ms = (ms > COUNT_MAX / 64'd1000) ? COUNT_MAX : ms * 64'd1000;
                  if (c == "s") unit_used = 1'b1;
               end
               emit_token(wait_pending ? KIND_WAIT : KIND_DELAY, ms);
               count_acc = '0;
               wait_pending = 1'b0;
               parse_phase = PH_TEXT;
               if (!unit_used) text_char(c);
            end
         end
         default: text_char(c);
      endcase
      // flag the final token of this character
      if (step_tokens.size() > 0) begin
         t = step_tokens.pop_back();
         t.last = 1'b1;
         step_tokens.push_back(t);
      end
   endfunction

   // offer one transaction, predict on acceptance, then maybe open a gap
   task automatic offer_char(input logic [7:0] c, input stim_row_type row);
      token_type t;
      req_char_code <= c;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      chars_sent++;
      decode_char(c);
      if (row.typed) begin
         t.kind = row.kind;
         t.value = row.value;
         t.last = 1'b1;
         pending_tokens.push_back(t);
      end else begin
         foreach (step_tokens[i]) pending_tokens.push_back(step_tokens[i]);
      end
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200)
                                                  : $urandom_range(1, 30);
      end else begin
         burst_left--;
      end
   endtask

   // hold the sender until every predicted token has come out
   task automatic drain_tokens();
      req_valid <= 1'b0;
      while (pending_tokens.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // append one script fragment, mostly well-formed escapes with random content
   task automatic queue_fragment();
      string hex_chars;
      string plain_escapes;
      int pick;
      int n;
      logic [7:0] c;
      hex_chars = "0123456789abcdefABCDEF";
      plain_escapes = "abfnrtvs89\\q";
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
         c = 8'($urandom_range(1, 255));
         if (c == "\\") c = "A";
         script_bytes.push_back(c);
      end else if (pick < 20) begin
         script_bytes.push_back(8'h00);
      end else if (pick < 35) begin
         script_bytes.push_back("\\");
         if ($urandom_range(0, 3) == 0) script_bytes.push_back(8'($urandom_range(0, 255)));
         else script_bytes.push_back(plain_escapes[$urandom_range(0, 11)]);
      end else if (pick < 50) begin
         script_bytes.push_back("\\");
         script_bytes.push_back("x");
         n = $urandom_range(0, 2);
         repeat (n) script_bytes.push_back(hex_chars[$urandom_range(0, 21)]);
         if ($urandom_range(0, 1) == 0) script_bytes.push_back(8'($urandom_range(0, 255)));
      end else if (pick < 65) begin
         script_bytes.push_back("\\");
         n = $urandom_range(1, 3);
         repeat (n) script_bytes.push_back(8'($urandom_range(48, 55)));
      end else if (pick < 90) begin
         script_bytes.push_back("\\");
         script_bytes.push_back(($urandom_range(0, 1) == 0) ? "d" : "w");
         n = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 12) : $urandom_range(0, 4);
         if ($urandom_range(0, 2) == 0) repeat (n) script_bytes.push_back("9");
         else repeat (n) script_bytes.push_back(8'($urandom_range(48, 57)));
         case ($urandom_range(0, 3))
            0: script_bytes.push_back("m");
            1: script_bytes.push_back("s");
            default: script_bytes.push_back(8'($urandom_range(0, 255)));
         endcase
      end else begin
         n = $urandom_range(1, 4);
         repeat (n) script_bytes.push_back(8'($urandom_range(0, 255)));
      end
   endtask

   // receiver: shifting stall patterns plus a periodic long hold-off
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (cycle_count % 2500 == 700) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES;
      end else begin
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 9) < 3);
            2: rsp_stall <= (cycle_count % 3 == 0);
            default: rsp_stall <= ($urandom_range(0, 9) < 7);
         endcase
      end
   end

   // compare each accepted token with the oldest prediction
   always @(posedge clock) begin
      token_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_tokens.size() == 0) begin
            $error("unexpected token: kind %0d value %0d last %0b",
                   rsp_token_kind, rsp_token_value, rsp_last_of_run);
            error_count++;
         end else begin
            want = pending_tokens.pop_front();
            tokens_checked++;
            if (want.kind == KIND_DELAY || want.kind == KIND_WAIT) timed_tokens++;
            if (rsp_token_kind !== want.kind) begin
               $error("token_kind: expected %0d, actual %0d", want.kind, rsp_token_kind);
               error_count++;
            end
            if (rsp_token_value !== want.value) begin
               $error("token_value: expected %0d, actual %0d", want.value, rsp_token_value);
               error_count++;
            end
            if (rsp_last_of_run !== want.last) begin
               $error("last_of_run: expected %0b, actual %0b", want.last, rsp_last_of_run);
               error_count++;
            end
         end
      end
   end

   initial begin
      int sent;
      stim_row_type no_row;
      no_row = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed script
      foreach (DIRECTED_ROWS[i]) offer_char(DIRECTED_ROWS[i].code, DIRECTED_ROWS[i]);
      drain_tokens();

      // random scripts, with one full pause in the middle
      sent = 0;
      while (sent < RANDOM_CHARS) begin
         if (script_bytes.size() == 0) queue_fragment();
         offer_char(script_bytes.pop_front(), no_row);
         sent++;
         if (sent == RANDOM_CHARS / 2) drain_tokens();
      end
      drain_tokens();

      if (pending_tokens.size() != 0) begin
         $error("%0d tokens never arrived", pending_tokens.size());
         error_count++;
      end
      $display("Sent %0d script characters; checked %0d tokens, %0d of them delay or wait.",
               chars_sent, tokens_checked, timed_tokens);
      if (error_count == 0) $display("chat_script_escape_decoder_unit_test: PASS");
      else $display("chat_script_escape_decoder_unit_test: FAIL");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/cse_pkg.sv
hdl/cse_decode.sv
hdl/chat_script_escape_decoder_unit.sv
tb/chat_script_escape_decoder_unit_test.sv
